// ----- rtl/core/lict_pkg.sv -----
package lict_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic CFG_LOCAL_ID = 1'b0;
  localparam logic CFG_VERSION  = 1'b1;

  localparam logic [7:0] LOCAL_ID_RESET = 8'd0;
  localparam logic [7:0] VERSION_RESET  = 8'd20;

  // register offsets, low four address bits cleared
  localparam logic [11:0] OFF_ID      = 12'h020;
  localparam logic [11:0] OFF_VERSION = 12'h030;
  localparam logic [11:0] OFF_EOI     = 12'h0B0;
  localparam logic [11:0] OFF_SPUR    = 12'h0F0;
  localparam logic [11:0] OFF_LVT     = 12'h320;
  localparam logic [11:0] OFF_INIT    = 12'h380;
  localparam logic [11:0] OFF_CUR     = 12'h390;
  localparam logic [11:0] OFF_DIV     = 12'h3E0;
  localparam logic [11:0] OFF_MASK    = 12'hFF0;

  localparam int unsigned SPUR_EN_BIT    = 8;
  localparam int unsigned LVT_MASK_BIT   = 16;
  localparam int unsigned LVT_PERIOD_BIT = 17;

  localparam logic [8:0]  SPUR_RESET = 9'h0FF;
  localparam logic [17:0] LVT_RESET  = 18'h10000;
  localparam logic [3:0]  DIV_KEEP   = 4'hB;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_fire;
    logic [7:0]  irq_vector;
  } result_t;

  // prescaler period for a divide code: code {b3,b1,b0} = 7 is divide by one
  function automatic logic [7:0] divisor_of(input logic [3:0] code);
    logic [2:0] v;
    v = {code[3], code[1:0]};
    if (v == 3'd7) begin
      divisor_of = 8'd1;
    end else begin
      divisor_of = 8'd2 << v;
    end
  endfunction

endpackage

// ----- rtl/core/lict_core.sv -----
module lict_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lict_pkg::cmd_e    cmd_i,
  input  logic [11:0]       addr_i,
  input  logic [31:0]       wdata_i,
  input  logic [7:0]        local_id_i,
  input  logic [7:0]        version_i,
  output lict_pkg::result_t res_o
);
  import lict_pkg::*;

  logic [8:0]             spur_q, spur_d;
  logic [17:0]            lvt_q, lvt_d;
  logic [COUNT_WIDTH-1:0] init_q, init_d;
  logic [COUNT_WIDTH-1:0] cur_q, cur_d;
  logic [COUNT_WIDTH-1:0] cur_dec;
  logic [3:0]             div_q, div_d;
  logic [6:0]             pre_q, pre_d;
  logic                   in_svc_q, in_svc_d;
  logic                   pend_q, pend_d;
  logic [11:0]            off;
  logic                   may_deliver;

  assign off         = addr_i & OFF_MASK;
  assign may_deliver = !lvt_q[LVT_MASK_BIT] && spur_q[SPUR_EN_BIT];
  assign cur_dec     = cur_q - COUNT_WIDTH'(1);

  always_comb begin
    spur_d   = spur_q;
    lvt_d    = lvt_q;
    init_d   = init_q;
    cur_d    = cur_q;
    div_d    = div_q;
    pre_d    = pre_q;
    in_svc_d = in_svc_q;
    pend_d   = pend_q;
    res_o    = '0;
    case (cmd_i)
      CMD_READ: begin
        case (off)
          OFF_ID:      res_o.rdata = {local_id_i, 24'd0};
          OFF_VERSION: res_o.rdata = {24'd0, version_i};
          OFF_SPUR:    res_o.rdata = {23'd0, spur_q};
          OFF_LVT:     res_o.rdata = {14'd0, lvt_q};
          OFF_INIT:    res_o.rdata = 32'(init_q);
          OFF_CUR:     res_o.rdata = 32'(cur_q);
          OFF_DIV:     res_o.rdata = {28'd0, div_q};
          default:     res_o.rdata = '0;
        endcase
      end
      CMD_WRITE: begin
        case (off)
          OFF_EOI: begin
            if (pend_q) begin
              pend_d = 1'b0;
              if (may_deliver) begin
                res_o.irq_fire   = 1'b1;
                res_o.irq_vector = lvt_q[7:0];
                in_svc_d         = 1'b1;
              end else begin
                in_svc_d = 1'b0;
              end
            end else begin
              in_svc_d = 1'b0;
            end
          end
          OFF_SPUR: spur_d = wdata_i[8:0];
          OFF_LVT:  lvt_d = {wdata_i[17:16], 8'd0, wdata_i[7:0]};
          OFF_INIT: begin
            init_d = wdata_i[COUNT_WIDTH-1:0];
            cur_d  = wdata_i[COUNT_WIDTH-1:0];
            pre_d  = '0;
          end
          OFF_DIV:  div_d = wdata_i[3:0] & DIV_KEEP;
          default:  ;
        endcase
      end
      CMD_TICK: begin
        if (cur_q != '0) begin
          if (({1'b0, pre_q} + 8'd1) >= divisor_of(div_q)) begin
            pre_d = '0;
            cur_d = cur_dec;
            if (cur_dec == '0) begin
              if (may_deliver) begin
                if (in_svc_q) begin
                  pend_d = 1'b1;
                end else begin
                  res_o.irq_fire   = 1'b1;
                  res_o.irq_vector = lvt_q[7:0];
                  in_svc_d         = 1'b1;
                end
              end
              if (lvt_q[LVT_PERIOD_BIT]) begin
                cur_d = init_q;
              end
            end
          end else begin
            pre_d = pre_q + 7'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spur_q   <= SPUR_RESET;
      lvt_q    <= LVT_RESET;
      init_q   <= '0;
      cur_q    <= '0;
      div_q    <= '0;
      pre_q    <= '0;
      in_svc_q <= 1'b0;
      pend_q   <= 1'b0;
    end else if (en_i) begin
      spur_q   <= spur_d;
      lvt_q    <= lvt_d;
      init_q   <= init_d;
      cur_q    <= cur_d;
      div_q    <= div_d;
      pre_q    <= pre_d;
      in_svc_q <= in_svc_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// ----- rtl/core/local_interrupt_controller_timer.sv -----
// Local interrupt controller timer with a 32-bit register file. Each request is a
// register read, a register write or one timer tick, and gives exactly one result
// carrying read data and any interrupt delivered with it. A request is registered on
// entry, processed in one pass and its result registered on exit, so the block takes
// one request per clock while results are taken; a result passes the input register and then the result register.
// A result that is not taken holds the request behind it and then stalls the input.
// The count registers are COUNT_WIDTH bits wide (up to 32).
module local_interrupt_controller_timer #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] addr_i,
  input  logic [31:0] wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] rdata_o,
  output logic        irq_fire_o,
  output logic [7:0]  irq_vector_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);
  import lict_pkg::*;

  logic        in_valid_q;
  logic [1:0]  cmd_q;
  logic [11:0] addr_q;
  logic [31:0] wdata_q;
  logic        out_valid_q;
  result_t     res_q, res_d;
  logic [7:0]  local_id_q;
  logic [7:0]  version_q;
  logic        in_accept;
  logic        advance;

  // the held request moves on when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  lict_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .cmd_i     (cmd_e'(cmd_q)),
    .addr_i    (addr_q),
    .wdata_i   (wdata_q),
    .local_id_i(local_id_q),
    .version_i (version_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      local_id_q  <= LOCAL_ID_RESET;
      version_q   <= VERSION_RESET;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LOCAL_ID: local_id_q <= cfg_wdata_i;
          CFG_VERSION:  version_q  <= cfg_wdata_i;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rdata_o      = res_q.rdata;
  assign irq_fire_o   = res_q.irq_fire;
  assign irq_vector_o = res_q.irq_vector;

endmodule

// ----- verif/local_interrupt_controller_timer_tb.sv -----
`timescale 1ns / 100ps

module local_interrupt_controller_timer_tb;
  import lict_pkg::*;

  localparam int unsigned CNT_W = 32;
  localparam logic [63:0] CNT_SPAN = 64'd1 << CNT_W;
  localparam logic [31:0] CNT_MASK = 32'(CNT_SPAN - 64'd1);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    cmd_e        cmd;
    logic [11:0] addr;
    logic [31:0] wdata;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = CMD_NOP;
  logic [11:0] addr_i = '0;
  logic [31:0] wdata_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] rdata_o;
  logic        irq_fire_o;
  logic [7:0]  irq_vector_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_LOCAL_ID;
  logic [7:0]  cfg_wdata_i = '0;

  local_interrupt_controller_timer #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rdata_o     (rdata_o),
    .irq_fire_o  (irq_fire_o),
    .irq_vector_o(irq_vector_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // model of the timer state
  logic [7:0]  id_q = LOCAL_ID_RESET;
  logic [7:0]  ver_q = VERSION_RESET;
  logic [8:0]  spur_q = SPUR_RESET;
  logic [17:0] lvt_q = LVT_RESET;
  logic [31:0] init_q = '0;
  logic [31:0] cur_q = '0;
  logic [3:0]  div_q = '0;
  logic [6:0]  pre_q = '0;
  logic        svc_q = 1'b0;
  logic        pend_q = 1'b0;

  req_t        bus_requests[$];
  result_t     due_results[$];
  req_t        next_req;
  logic        req_taken = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_arm = 1'b0;
  logic        hold_started = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic [11:0] reg_offs[8] = '{OFF_ID, OFF_VERSION, OFF_EOI, OFF_SPUR,
                               OFF_LVT, OFF_INIT, OFF_CUR, OFF_DIV};

  function automatic int unsigned prescale_period(logic [3:0] code);
    logic [2:0] sel;
    sel = {code[3], code[1:0]};
    return (sel == 3'd7) ? 1 : (1 << (int'(sel) + 1));
  endfunction

  function automatic logic delivery_open();
    return !lvt_q[LVT_MASK_BIT] && spur_q[SPUR_EN_BIT];
  endfunction

  function automatic result_t timer_response(req_t r);
    result_t     res;
    logic [11:0] off;
    res = '0;
    off = r.addr & OFF_MASK;
    case (r.cmd)
      CMD_READ: begin
        case (off)
          OFF_ID:      res.rdata = {id_q, 24'd0};
          OFF_VERSION: res.rdata = {24'd0, ver_q};
          OFF_SPUR:    res.rdata = 32'(spur_q);
          OFF_LVT:     res.rdata = 32'(lvt_q);
          OFF_INIT:    res.rdata = init_q;
          OFF_CUR:     res.rdata = cur_q;
          OFF_DIV:     res.rdata = 32'(div_q);
          default:     res.rdata = '0;
        endcase
      end
      CMD_WRITE: begin
        case (off)
          OFF_EOI: begin
            // a held expiry goes out now if delivery is still allowed
            if (pend_q) begin
              pend_q = 1'b0;
              if (delivery_open()) begin
                res.irq_fire = 1'b1;
                res.irq_vector = lvt_q[7:0];
                svc_q = 1'b1;
              end else begin
                svc_q = 1'b0;
              end
            end else begin
              svc_q = 1'b0;
            end
          end
          OFF_SPUR: spur_q = r.wdata[8:0];
          OFF_LVT:  lvt_q = {r.wdata[17:16], 8'd0, r.wdata[7:0]};
          OFF_INIT: begin
            init_q = r.wdata & CNT_MASK;
            cur_q = init_q;
            pre_q = '0;
          end
          OFF_DIV:  div_q = r.wdata[3:0] & DIV_KEEP;
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (cur_q != '0) begin
          if (32'(pre_q) + 32'd1 >= prescale_period(div_q)) begin
            pre_q = '0;
            cur_q = (cur_q - 32'd1) & CNT_MASK;
            if (cur_q == '0) begin
              if (delivery_open()) begin
                if (svc_q) begin
                  pend_q = 1'b1;
                end else begin
                  res.irq_fire = 1'b1;
                  res.irq_vector = lvt_q[7:0];
                  svc_q = 1'b1;
                end
              end
              if (lvt_q[LVT_PERIOD_BIT]) begin
                cur_q = init_q;
              end
            end
          end else begin
            pre_q = pre_q + 7'd1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // low address nibble is don't-care, so randomize it
  function automatic void add_req(cmd_e c, logic [11:0] off, logic [31:0] wd);
    req_t r;
    r.cmd = c;
    r.addr = off | 12'($urandom_range(0, 15));
    r.wdata = wd;
    bus_requests.push_back(r);
  endfunction

  function automatic logic [31:0] spur_word();
    logic [31:0] w;
    w = $urandom();
    w[SPUR_EN_BIT] = ($urandom_range(0, 9) < 8);
    return w;
  endfunction

  function automatic logic [31:0] lvt_word();
    logic [31:0] w;
    w = $urandom();
    w[LVT_MASK_BIT] = ($urandom_range(0, 4) == 0);
    return w;
  endfunction

  function automatic logic [31:0] div_word();
    logic [31:0] w;
    logic [3:0]  code;
    int unsigned pick;
    w = $urandom();
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      code = 4'hB;
    end else if (pick < 7) begin
      code = 4'h0;
    end else if (pick == 7) begin
      code = 4'h1;
    end else if (pick == 8) begin
      code = 4'h2;
    end else begin
      code = 4'($urandom());
    end
    w[3] = code[3];
    w[1:0] = code[1:0];
    return w;
  endfunction

  function automatic logic [31:0] init_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return $urandom();
    end
    return 32'($urandom_range(1, 12));
  endfunction

  // mostly program-then-run sequences, some raw noise in between
  task automatic load_random(int unsigned n);
    int unsigned made;
    int unsigned body;
    int unsigned pick;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 15) begin
        add_req(cmd_e'($urandom_range(0, 3)), 12'($urandom()), $urandom());
        made++;
      end else begin
        add_req(CMD_WRITE, OFF_SPUR, spur_word());
        add_req(CMD_WRITE, OFF_LVT, lvt_word());
        add_req(CMD_WRITE, OFF_DIV, div_word());
        add_req(CMD_WRITE, OFF_INIT, init_word());
        body = $urandom_range(8, 50);
        made += body + 4;
        repeat (body) begin
          pick = $urandom_range(0, 99);
          if (pick < 68) begin
            add_req(CMD_TICK, 12'($urandom()), $urandom());
          end else if (pick < 80) begin
            add_req(CMD_WRITE, OFF_EOI, $urandom());
          end else if (pick < 93) begin
            if ($urandom_range(0, 8) == 0) begin
              add_req(CMD_READ, 12'($urandom()), $urandom());
            end else begin
              add_req(CMD_READ, reg_offs[$urandom_range(0, 7)], $urandom());
            end
          end else if (pick < 96) begin
            add_req(CMD_WRITE, OFF_LVT, lvt_word());
          end else if (pick < 98) begin
            add_req(CMD_WRITE, OFF_SPUR, spur_word());
          end else begin
            add_req(CMD_WRITE, OFF_INIT, init_word());
          end
        end
      end
    end
  endtask

  task automatic drain();
    while (bus_requests.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (bus_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_req = bus_requests.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= next_req.cmd;
        addr_i <= next_req.addr;
        wdata_i <= next_req.wdata;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back up the pipeline
  always @(negedge clk_i) begin
    if (hold_arm && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk_i) begin
    result_t want;
    req_t    seen;
    req_taken = in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_LOCAL_ID) begin
          id_q = cfg_wdata_i;
        end else begin
          ver_q = cfg_wdata_i;
        end
      end
      if (req_taken) begin
        seen.cmd = cmd_e'(cmd_i);
        seen.addr = addr_i;
        seen.wdata = wdata_i;
        due_results.push_back(timer_response(seen));
      end
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, rdata %h irq_fire %b irq_vector %h",
                   $time, rdata_o, irq_fire_o, irq_vector_o);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (rdata_o !== want.rdata) begin
            $display("%0t: rdata mismatch, expected %h, got %h", $time, want.rdata, rdata_o);
            mismatches++;
          end
          if (irq_fire_o !== want.irq_fire) begin
            $display("%0t: irq_fire mismatch, expected %b, got %b",
                     $time, want.irq_fire, irq_fire_o);
            mismatches++;
          end
          if (irq_vector_o !== want.irq_vector) begin
            $display("%0t: irq_vector mismatch, expected %h, got %h",
                     $time, want.irq_vector, irq_vector_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle_pct = 7;
    rx_idle_pct = 66;
    add_req(CMD_READ, OFF_ID, '1);
    add_req(CMD_READ, OFF_VERSION, '0);
    add_req(CMD_READ, OFF_EOI, '0);
    add_req(CMD_READ, OFF_MASK, '0);
    add_req(CMD_NOP, OFF_LVT, '1);
    // counter is stopped after reset
    add_req(CMD_TICK, 12'h000, '1);
    add_req(CMD_WRITE, 12'h000, '1);
    add_req(CMD_WRITE, OFF_CUR, '1);
    add_req(CMD_WRITE, OFF_ID, '1);
    add_req(CMD_WRITE, OFF_DIV, '1);
    add_req(CMD_WRITE, OFF_SPUR, '1);
    add_req(CMD_WRITE, OFF_LVT, 32'hFFFE_FFAA);
    add_req(CMD_WRITE, OFF_INIT, 32'd1);
    // fire, then expire twice while in service
    add_req(CMD_TICK, OFF_ID, '0);
    add_req(CMD_TICK, OFF_ID, '0);
    add_req(CMD_TICK, OFF_ID, '0);
    add_req(CMD_WRITE, OFF_EOI, '0);
    add_req(CMD_WRITE, OFF_EOI, '1);
    // masked periodic expiry is dropped but still reloads
    add_req(CMD_WRITE, OFF_LVT, 32'h0003_0055);
    add_req(CMD_TICK, OFF_ID, '0);
    add_req(CMD_READ, OFF_LVT, '0);
    add_req(CMD_WRITE, OFF_INIT, '0);
    add_req(CMD_TICK, OFF_ID, '0);
    add_req(CMD_WRITE, OFF_INIT, '1);
    add_req(CMD_READ, OFF_INIT, '0);
    add_req(CMD_READ, OFF_CUR, '0);
    drain();

    write_cfg(CFG_LOCAL_ID, 8'hFF);
    write_cfg(CFG_VERSION, 8'h00);
    hold_arm = 1'b1;
    load_random(260);
    drain();

    tx_idle_pct = 66;
    rx_idle_pct = 7;
    write_cfg(CFG_LOCAL_ID, 8'h00);
    write_cfg(CFG_VERSION, 8'hFF);
    load_random(260);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(CFG_LOCAL_ID, 8'($urandom()));
    write_cfg(CFG_VERSION, 8'($urandom()));
    load_random(260);
    drain();

    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
